// File: rtl/bmac_pkg.sv
// Shared types and fixed widths for the blocked matrix multiply-accumulate core.
// Used by the channel interfaces, the MAC unit and the top level.
`timescale 1ns / 1ps
`default_nettype none

package bmac_pkg;

   localparam int VALUE_W = 16;
   localparam int SUM_W   = 48;
   localparam int ROW_W   = 3;
   localparam int COL_W   = 3;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic signed [SUM_W-1:0]   sum_type;

   typedef struct packed {
      value_type a_value;
      value_type b_value;
      logic      final_block;
   } req_word_type;

   typedef struct packed {
      sum_type          sum_value;
      logic [ROW_W-1:0] out_row;
      logic [COL_W-1:0] out_col;
      logic             last;
   } rsp_word_type;

   // Tag that travels with each product through the MAC pipeline.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctrl_type;

endpackage

`default_nettype wire

// File: rtl/bmac_req_if.sv
// Request channel: valid/ready handshake carrying one load word.
// Depends on bmac_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bmac_req_if;
   logic                  valid;
   logic                  ready;
   bmac_pkg::req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/bmac_rsp_if.sv
// Response channel: valid/ready handshake carrying one result word.
// Depends on bmac_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bmac_rsp_if;
   logic                  valid;
   logic                  ready;
   bmac_pkg::rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/bmac_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bmac_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/bmac_mac_unit.sv
// Shared multiply-accumulate unit: one 16x16 multiplier, dot-product
// accumulator and saturating 48-bit add. Depends on bmac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmac_mac_unit #(
   parameter int INNER = 4
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire bmac_pkg::value_type     a_data,
   input  wire bmac_pkg::value_type     b_data,
   input  wire bmac_pkg::mac_ctrl_type  ctrl_in,
   output bmac_pkg::mac_ctrl_type       ctrl_mid,
   output bmac_pkg::mac_ctrl_type       ctrl_out,
   input  wire bmac_pkg::sum_type       acc_in,
   output bmac_pkg::sum_type            sat_out
);

   localparam int PROD_W = 2 * bmac_pkg::VALUE_W;
   localparam int DOT_W  = PROD_W + 1 + ((INNER > 1) ? $clog2(INNER) : 0);
   localparam int WIDE_W = bmac_pkg::SUM_W + 1;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [DOT_W-1:0]  dot_ff, dot_in;
   logic signed [WIDE_W-1:0] wide;
   bmac_pkg::mac_ctrl_type   ctrl2_ff, ctrl3_ff;

   assign prod_in = a_data * b_data;
   assign dot_in  = ctrl2_ff.first ? DOT_W'(prod_ff) : dot_ff + DOT_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl2_ff <= '0;
         ctrl3_ff <= '0;
      end else begin
         ctrl2_ff <= ctrl_in;
         ctrl3_ff <= ctrl2_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (ctrl2_ff.valid) begin
         dot_ff <= dot_in;
      end
   end

   assign wide = {acc_in[bmac_pkg::SUM_W-1], acc_in} + WIDE_W'(dot_ff);

   always_comb begin
      if (wide[WIDE_W-1] != wide[WIDE_W-2]) begin
         sat_out = wide[WIDE_W-1] ? {1'b1, {(bmac_pkg::SUM_W-1){1'b0}}}
                                  : {1'b0, {(bmac_pkg::SUM_W-1){1'b1}}};
      end else begin
         sat_out = wide[bmac_pkg::SUM_W-1:0];
      end
   end

   assign ctrl_mid = ctrl2_ff;
   assign ctrl_out = ctrl3_ff;

endmodule

`default_nettype wire

// File: rtl/block_matrix_multiply_accumulate_core.sv
// Blocked matrix multiply-accumulate core: C(ROWS x COLS) += A(ROWS x INNER) * B(INNER x COLS).
// Depends on bmac_pkg, bmac_req_if, bmac_rsp_if, bmac_ram, bmac_mac_unit.
//
// Usage:
//   req_chan carries one word per A/B element pair, both blocks in row-major
//   order; a pair takes max(ROWS*INNER, INNER*COLS) words. The flag
//   final_block counts only on the word that completes a pair.
//   After a pair completes, one shared multiplier runs ROWS*COLS*INNER
//   multiply-accumulates, one per cycle, then the pipeline drains;
//   req_chan.ready is low meanwhile. With final_block set, the ROWS*COLS
//   saturated sums leave on rsp_chan in row-major order, last marked on the
//   final word; each word is read from the sum RAM, registered and held until
//   taken before the next is read; a stalled receiver holds the word and the
//   block waits. The sums are then cleared.
//   Reset clears the sums (valid bits per entry) and restarts loading.
`timescale 1ns / 1ps
`default_nettype none

module block_matrix_multiply_accumulate_core #(
   parameter int ROWS  = 8,
   parameter int INNER = 4,
   parameter int COLS  = 8
) (
   input  wire logic      clock,
   input  wire logic      reset,
   bmac_req_if.sink       req_chan,
   bmac_rsp_if.source     rsp_chan
);

   localparam int A_SIZE = ROWS * INNER;
   localparam int B_SIZE = INNER * COLS;
   localparam int C_SIZE = ROWS * COLS;
   localparam int PAIR   = (A_SIZE > B_SIZE) ? A_SIZE : B_SIZE;
   localparam int A_AW   = (A_SIZE > 1) ? $clog2(A_SIZE) : 1;
   localparam int B_AW   = (B_SIZE > 1) ? $clog2(B_SIZE) : 1;
   localparam int C_AW   = (C_SIZE > 1) ? $clog2(C_SIZE) : 1;
   localparam int PW     = (PAIR > 1) ? $clog2(PAIR) : 1;
   localparam int KW     = (INNER > 1) ? $clog2(INNER) : 1;
   localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CW     = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int VW     = bmac_pkg::VALUE_W;
   localparam int SW     = bmac_pkg::SUM_W;

   localparam logic [2:0] S_LOAD      = 3'd0;
   localparam logic [2:0] S_CALC      = 3'd1;
   localparam logic [2:0] S_DRAIN     = 3'd2;
   localparam logic [2:0] S_EMIT_RD   = 3'd3;
   localparam logic [2:0] S_EMIT_LD   = 3'd4;
   localparam logic [2:0] S_EMIT_HOLD = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [PW-1:0]         pos_ff, pos_in;
   logic                  final_ff, final_in;
   logic [KW-1:0]         k_ff, k_in;
   logic [RW-1:0]         r_ff, r_in;
   logic [CW-1:0]         c_ff, c_in;
   logic [A_AW-1:0]       a_addr_ff, a_addr_in, a_base_ff, a_base_in;
   logic [B_AW-1:0]       b_addr_ff, b_addr_in;
   logic [C_AW-1:0]       caddr_ff, caddr_in;
   logic [C_AW-1:0]       p1_caddr_ff, p2_caddr_ff, p3_caddr_ff;
   bmac_pkg::mac_ctrl_type ctrl1_ff, ctrl1_in, ctrl_mid, ctrl_out;
   logic [C_SIZE-1:0]     sum_vld_ff;
   logic                  vread_ff;
   bmac_pkg::rsp_word_type rsp_ff;
   logic                  rsp_valid_ff;

   logic                  req_accept, rsp_accept, issue, pair_done, step_adv;
   logic                  a_wr_en, b_wr_en, c_wr_en;
   logic [VW-1:0]         a_rd_data, b_rd_data;
   logic [SW-1:0]         c_rd_data;
   logic [C_AW-1:0]       c_rd_addr;
   bmac_pkg::sum_type     acc_in, sat_out;

   assign req_chan.ready = (state_ff == S_LOAD);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_ff;
   assign rsp_accept     = rsp_valid_ff && rsp_chan.ready;
   assign pair_done      = (pos_ff == PW'(PAIR - 1));
   assign issue          = (state_ff == S_CALC);
   assign step_adv       = issue || ((state_ff == S_EMIT_HOLD) && rsp_accept);

   assign a_wr_en = req_accept && ({1'b0, pos_ff} < (PW + 1)'(A_SIZE));
   assign b_wr_en = req_accept && ({1'b0, pos_ff} < (PW + 1)'(B_SIZE));

   bmac_ram #(.WIDTH(VW), .DEPTH(A_SIZE)) u_left_ram (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (pos_ff[A_AW-1:0]),
      .wr_data (req_chan.data.a_value),
      .rd_addr (a_addr_ff),
      .rd_data (a_rd_data)
   );

   bmac_ram #(.WIDTH(VW), .DEPTH(B_SIZE)) u_right_ram (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (pos_ff[B_AW-1:0]),
      .wr_data (req_chan.data.b_value),
      .rd_addr (b_addr_ff),
      .rd_data (b_rd_data)
   );

   assign c_rd_addr = (state_ff == S_EMIT_RD) ? caddr_ff : p2_caddr_ff;
   assign c_wr_en   = ctrl_out.valid && ctrl_out.last;

   bmac_ram #(.WIDTH(SW), .DEPTH(C_SIZE)) u_sum_ram (
      .clock   (clock),
      .wr_en   (c_wr_en),
      .wr_addr (p3_caddr_ff),
      .wr_data (sat_out),
      .rd_addr (c_rd_addr),
      .rd_data (c_rd_data)
   );

   assign acc_in = vread_ff ? c_rd_data : '0;

   bmac_mac_unit #(.INNER(INNER)) u_mac_unit (
      .clock    (clock),
      .reset    (reset),
      .a_data   ($signed(a_rd_data)),
      .b_data   ($signed(b_rd_data)),
      .ctrl_in  (ctrl1_ff),
      .ctrl_mid (ctrl_mid),
      .ctrl_out (ctrl_out),
      .acc_in   (acc_in),
      .sat_out  (sat_out)
   );

   // Sequencer and address walk: k inner, then column, then row.
   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      final_in  = final_ff;
      k_in      = k_ff;
      r_in      = r_ff;
      c_in      = c_ff;
      a_addr_in = a_addr_ff;
      a_base_in = a_base_ff;
      b_addr_in = b_addr_ff;
      caddr_in  = caddr_ff;
      ctrl1_in.valid = issue;
      ctrl1_in.first = (k_ff == '0);
      ctrl1_in.last  = (k_ff == KW'(INNER - 1));

      if (step_adv) begin
         if (!issue || (k_ff == KW'(INNER - 1))) begin
            k_in     = '0;
            caddr_in = caddr_ff + 1'b1;
            if (c_ff == CW'(COLS - 1)) begin
               c_in      = '0;
               b_addr_in = '0;
               if (r_ff == RW'(ROWS - 1)) begin
                  r_in      = '0;
                  a_base_in = '0;
                  a_addr_in = '0;
                  caddr_in  = '0;
               end else begin
                  r_in      = r_ff + 1'b1;
                  a_base_in = a_base_ff + A_AW'(INNER);
                  a_addr_in = a_base_ff + A_AW'(INNER);
               end
            end else begin
               c_in      = c_ff + 1'b1;
               a_addr_in = a_base_ff;
               b_addr_in = B_AW'(c_ff) + 1'b1;
            end
         end else begin
            k_in      = k_ff + 1'b1;
            a_addr_in = a_addr_ff + 1'b1;
            b_addr_in = b_addr_ff + B_AW'(COLS);
         end
      end

      unique case (state_ff)
         S_LOAD: begin
            if (req_accept) begin
               if (pair_done) begin
                  pos_in   = '0;
                  final_in = req_chan.data.final_block;
                  state_in = S_CALC;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
         S_CALC: begin
            if ((k_ff == KW'(INNER - 1)) && (c_ff == CW'(COLS - 1)) &&
                (r_ff == RW'(ROWS - 1))) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!ctrl1_ff.valid && !ctrl_mid.valid && !ctrl_out.valid) begin
               state_in = final_ff ? S_EMIT_RD : S_LOAD;
            end
         end
         S_EMIT_RD: begin
            state_in = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            state_in = S_EMIT_HOLD;
         end
         S_EMIT_HOLD: begin
            if (rsp_accept) begin
               state_in = (caddr_ff == C_AW'(C_SIZE - 1)) ? S_LOAD : S_EMIT_RD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         pos_ff       <= '0;
         final_ff     <= 1'b0;
         k_ff         <= '0;
         r_ff         <= '0;
         c_ff         <= '0;
         a_addr_ff    <= '0;
         a_base_ff    <= '0;
         b_addr_ff    <= '0;
         caddr_ff     <= '0;
         ctrl1_ff     <= '0;
         sum_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         final_ff  <= final_in;
         k_ff      <= k_in;
         r_ff      <= r_in;
         c_ff      <= c_in;
         a_addr_ff <= a_addr_in;
         a_base_ff <= a_base_in;
         b_addr_ff <= b_addr_in;
         caddr_ff  <= caddr_in;
         ctrl1_ff  <= ctrl1_in;
         if ((state_ff == S_EMIT_HOLD) && rsp_accept &&
             (caddr_ff == C_AW'(C_SIZE - 1))) begin
            sum_vld_ff <= '0;
         end else if (c_wr_en) begin
            sum_vld_ff[p3_caddr_ff] <= 1'b1;
         end
         if (state_ff == S_EMIT_LD) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_accept) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      p1_caddr_ff <= caddr_ff;
      p2_caddr_ff <= p1_caddr_ff;
      p3_caddr_ff <= p2_caddr_ff;
      vread_ff    <= sum_vld_ff[c_rd_addr];
      if (state_ff == S_EMIT_LD) begin
         rsp_ff.sum_value <= acc_in;
         rsp_ff.out_row   <= bmac_pkg::ROW_W'(r_ff);
         rsp_ff.out_col   <= bmac_pkg::COL_W'(c_ff);
         rsp_ff.last      <= (caddr_ff == C_AW'(C_SIZE - 1));
      end
   end

endmodule

`default_nettype wire

// File: rtl/bmac_checker.sv
// Port-level checks for the blocked matrix multiply-accumulate core.
// Bound to block_matrix_multiply_accumulate_core; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module bmac_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_last
);

   a_no_load_while_emitting: assert property (
      @(posedge clock) disable iff (reset) rsp_valid |-> !req_ready)
      else $error("input ready while a result word is pending");

   a_rsp_held_on_stall: assert property (
      @(posedge clock) disable iff (reset) (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_reset_clears_rsp: assert property (
      @(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_ready_after_last: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> (req_ready && !rsp_valid))
      else $error("block not back to loading after last word");

endmodule

bind block_matrix_multiply_accumulate_core bmac_checker u_bmac_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_last  (rsp_chan.data.last)
);

`default_nettype wire
